FILE: design/esie_pkg.sv
package esie_pkg;

  localparam int TABLE_BYTES = 512;
  localparam int TAB_AW      = $clog2(TABLE_BYTES);
  localparam int HDR_LEN     = 52;
  localparam logic [31:0] ELF_MAGIC   = 32'h464c457f;
  localparam logic [15:0] ELF_EXEC    = 16'd2;
  localparam logic [15:0] MACHINE_ARM = 16'd40;
  localparam logic [31:0] PT_LOAD     = 32'd1;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_NOT_ARM   = 2'd0;
  localparam logic [1:0] ERR_BEHIND    = 2'd1;
  localparam logic [1:0] ERR_TABLE_BIG = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] address;
    logic [31:0] fill_length;
    logic [1:0]  error_code;
    logic        last_of_run;
  } result_t;

  function automatic result_t mk_result(logic [1:0] kind, logic [7:0] val,
                                        logic [31:0] addr, logic [31:0] len,
                                        logic [1:0] err);
    result_t r;
    r.kind        = kind;
    r.byte_value  = val;
    r.address     = addr;
    r.fill_length = len;
    r.error_code  = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

FILE: design/esie_ram.sv
module esie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/esie_queue.sv
module esie_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  esie_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output esie_pkg::result_t out_data
);
  import esie_pkg::*;

  result_t         slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r;
  logic [Q_AW-1:0] rd_r;
  logic [Q_AW:0]   count_r;
  logic            pop;

  assign full      = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = slot_r[rd_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        slot_r[wr_r] <= push_data;
        wr_r         <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      count_r <= count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

endmodule

FILE: design/esie_front.sv
module esie_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  output logic              in_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output esie_pkg::result_t q_data
);
  import esie_pkg::*;

  typedef enum logic [1:0] {
    MODE_CAPTURE, MODE_STREAM, MODE_ENDED, MODE_FAILED
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAPT, ST_WCHK, ST_WISS, ST_WGET, ST_WDEC,
    ST_STRA, ST_STRB, ST_STRC, ST_STRD, ST_STRT, ST_FIN, ST_FLUSH
  } state_t;

  typedef enum logic [1:0] { FLD_TYPE, FLD_FSZ, FLD_OFF, FLD_PA } fld_t;

  state_t      state_r;
  mode_t       mode_r;
  fld_t        fld_r;
  logic [7:0]  byte_r;
  logic [31:0] pos_r;
  logic [31:0] oa_r;
  logic [7:0]  hdr_r [HDR_LEN];
  logic [31:0] tsize_r;
  logic [32:0] tend_r;
  logic [15:0] seg_r;
  logic [31:0] base_r;
  logic [1:0]  b_r;
  logic [31:0] acc_r;
  logic        is_load_r;
  logic        bvalid_r;
  logic [32:0] wpos_r;
  logic        wret_r;
  logic [31:0] sfo_r;
  logic [31:0] spa_r;
  logic [31:0] sfs_r;
  logic [31:0] diff_r;
  logic [31:0] phys_r;
  result_t     pend_r;
  logic        pend_v_r;

  logic [31:0] tstart;
  logic [15:0] phent;
  logic [15:0] phnum;
  logic        bad_hdr;
  logic        big_tab;
  logic        in_tab;
  logic        hold;
  logic        emit_v;
  result_t     emit_rec;
  logic [4:0]  fofs;
  logic [32:0] idx;
  logic        ram_we;
  logic [7:0]  ram_rdata;
  logic [31:0] acc_nxt;

  assign tstart  = {hdr_r[31], hdr_r[30], hdr_r[29], hdr_r[28]};
  assign phent   = {hdr_r[43], hdr_r[42]};
  assign phnum   = {hdr_r[45], hdr_r[44]};
  assign bad_hdr = ({hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]} != ELF_MAGIC) ||
                   ({hdr_r[17], hdr_r[16]} != ELF_EXEC) ||
                   ({hdr_r[19], hdr_r[18]} != MACHINE_ARM);
  assign big_tab = (tsize_r > 32'(TABLE_BYTES)) || tend_r[32];
  assign in_tab  = ({1'b0, pos_r} < tend_r);
  assign hold    = pend_v_r && q_full;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (fld_r)
      FLD_TYPE: fofs = 5'd0;
      FLD_FSZ:  fofs = 5'd16;
      FLD_OFF:  fofs = 5'd4;
      FLD_PA:   fofs = 5'd12;
      default:  fofs = 5'd0;
    endcase
  end

  assign idx = {1'b0, base_r} + 33'(fofs) + 33'(b_r);

  always_comb begin
    acc_nxt = acc_r;
    acc_nxt[8*b_r +: 8] = bvalid_r ? ram_rdata : 8'h00;
  end

  // Table bytes are written while the header is already captured and checked.
  assign ram_we = (state_r == ST_CAPT) && !hold && (pos_r >= 32'(HDR_LEN)) &&
                  (pos_r >= tstart) && !big_tab && in_tab;

  esie_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (TAB_AW'(pos_r - tstart)),
    .wdata (byte_r),
    .raddr (idx[TAB_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    emit_v   = 1'b0;
    emit_rec = mk_result(KIND_DATA, 8'h00, 32'd0, 32'd0, ERR_NOT_ARM);
    unique case (state_r)
      ST_CAPT: begin
        if (pos_r < 32'(HDR_LEN)) begin
          if (pos_r == 32'(HDR_LEN - 1) && bad_hdr) begin
            emit_v   = 1'b1;
            emit_rec = mk_result(KIND_ERROR, 8'h00, 32'd0, 32'd0, ERR_NOT_ARM);
          end
        end else if (pos_r >= tstart && big_tab) begin
          emit_v   = 1'b1;
          emit_rec = mk_result(KIND_ERROR, 8'h00, 32'd0, 32'd0, ERR_TABLE_BIG);
        end
      end
      ST_WCHK: begin
        if (seg_r >= phnum) begin
          emit_v   = 1'b1;
          emit_rec = mk_result(KIND_END, 8'h00, 32'd0, 32'd0, ERR_NOT_ARM);
        end
      end
      ST_WDEC: begin
        if (fld_r == FLD_OFF && {1'b0, acc_r} < wpos_r) begin
          emit_v   = 1'b1;
          emit_rec = mk_result(KIND_ERROR, 8'h00, 32'd0, 32'd0, ERR_BEHIND);
        end
      end
      ST_STRC: begin
        if (phys_r > oa_r) begin
          emit_v   = 1'b1;
          emit_rec = mk_result(KIND_FILL, 8'h00, oa_r, phys_r - oa_r, ERR_NOT_ARM);
        end else if (phys_r == oa_r) begin
          emit_v   = 1'b1;
          emit_rec = mk_result(KIND_DATA, byte_r, phys_r, 32'd0, ERR_NOT_ARM);
        end
      end
      ST_STRD: begin
        emit_v   = 1'b1;
        emit_rec = mk_result(KIND_DATA, byte_r, phys_r, 32'd0, ERR_NOT_ARM);
      end
      ST_FIN: begin
        if (pos_r == 32'hffff_ffff &&
            (mode_r == MODE_CAPTURE || mode_r == MODE_STREAM)) begin
          emit_v   = 1'b1;
          emit_rec = mk_result(KIND_END, 8'h00, 32'd0, 32'd0, ERR_NOT_ARM);
        end
      end
      default: begin
      end
    endcase
  end

  // The held result is released once it is known whether another follows it.
  always_comb begin
    q_push = !hold && pend_v_r && (emit_v || state_r == ST_FLUSH);
    q_data = pend_r;
    q_data.last_of_run = (state_r == ST_FLUSH);
  end

  always_ff @(posedge clk) begin
    tsize_r <= 32'(phent) * 32'(phnum);
    tend_r  <= {1'b0, tstart} + {1'b0, tsize_r};
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= MODE_CAPTURE;
      pos_r    <= '0;
      oa_r     <= '0;
      seg_r    <= '0;
      base_r   <= '0;
      sfo_r    <= '0;
      spa_r    <= '0;
      sfs_r    <= '0;
      pend_v_r <= 1'b0;
      fld_r    <= FLD_TYPE;
      b_r      <= '0;
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr_r[i] <= 8'h00;
      end
    end else begin
      if (cfg_valid) begin
        if (pos_r == 32'd0) begin
          oa_r <= cfg_data;
        end
      end
      if (!hold) begin
        if (emit_v) begin
          pend_r   <= emit_rec;
          pend_v_r <= 1'b1;
        end else if (state_r == ST_FLUSH) begin
          pend_v_r <= 1'b0;
        end
        unique case (state_r)
          ST_IDLE: begin
            if (in_valid) begin
              byte_r <= in_data_byte;
              unique case (mode_r)
                MODE_CAPTURE: state_r <= ST_CAPT;
                MODE_STREAM:  state_r <= ST_STRA;
                default:      state_r <= ST_IDLE;
              endcase
            end
          end
          ST_CAPT: begin
            if (pos_r < 32'(HDR_LEN)) begin
              hdr_r[pos_r[5:0]] <= byte_r;
              if (pos_r == 32'(HDR_LEN - 1) && bad_hdr) begin
                mode_r <= MODE_FAILED;
              end
              state_r <= ST_FIN;
            end else if (pos_r >= tstart) begin
              if (big_tab) begin
                mode_r  <= MODE_FAILED;
                state_r <= ST_FIN;
              end else if (in_tab) begin
                if ({1'b0, pos_r} + 33'd1 == tend_r) begin
                  wpos_r  <= {1'b0, pos_r} + 33'd1;
                  wret_r  <= 1'b0;
                  state_r <= ST_WCHK;
                end else begin
                  state_r <= ST_FIN;
                end
              end else begin
                wpos_r  <= {1'b0, pos_r};
                wret_r  <= 1'b1;
                state_r <= ST_WCHK;
              end
            end else begin
              state_r <= ST_FIN;
            end
          end
          ST_WCHK: begin
            if (seg_r < phnum) begin
              fld_r   <= FLD_TYPE;
              b_r     <= '0;
              state_r <= ST_WISS;
            end else begin
              mode_r  <= MODE_ENDED;
              state_r <= ST_FIN;
            end
          end
          ST_WISS: begin
            bvalid_r <= (idx < {1'b0, tsize_r}) && (idx < 33'(TABLE_BYTES));
            state_r  <= ST_WGET;
          end
          ST_WGET: begin
            acc_r <= acc_nxt;
            b_r   <= b_r + 1'b1;
            state_r <= (b_r == 2'd3) ? ST_WDEC : ST_WISS;
          end
          ST_WDEC: begin
            unique case (fld_r)
              FLD_TYPE: begin
                is_load_r <= (acc_r == PT_LOAD);
                fld_r     <= FLD_FSZ;
                state_r   <= ST_WISS;
              end
              FLD_FSZ: begin
                if (!is_load_r || acc_r == 32'd0) begin
                  seg_r   <= seg_r + 1'b1;
                  base_r  <= base_r + 32'(phent);
                  state_r <= ST_WCHK;
                end else begin
                  sfs_r   <= acc_r;
                  fld_r   <= FLD_OFF;
                  state_r <= ST_WISS;
                end
              end
              FLD_OFF: begin
                if ({1'b0, acc_r} < wpos_r) begin
                  mode_r  <= MODE_FAILED;
                  state_r <= ST_FIN;
                end else begin
                  sfo_r   <= acc_r;
                  fld_r   <= FLD_PA;
                  state_r <= ST_WISS;
                end
              end
              FLD_PA: begin
                spa_r   <= acc_r;
                mode_r  <= MODE_STREAM;
                state_r <= wret_r ? ST_STRA : ST_FIN;
              end
              default: state_r <= ST_FIN;
            endcase
          end
          ST_STRA: begin
            diff_r  <= pos_r - sfo_r;
            state_r <= (pos_r < sfo_r) ? ST_FIN : ST_STRB;
          end
          ST_STRB: begin
            phys_r  <= spa_r + diff_r;
            state_r <= ST_STRC;
          end
          ST_STRC: begin
            if (phys_r > oa_r) begin
              oa_r    <= phys_r;
              state_r <= ST_STRD;
            end else begin
              if (phys_r == oa_r) begin
                oa_r <= phys_r + 32'd1;
              end
              state_r <= ST_STRT;
            end
          end
          ST_STRD: begin
            oa_r    <= phys_r + 32'd1;
            state_r <= ST_STRT;
          end
          ST_STRT: begin
            if ({1'b0, pos_r} + 33'd1 == {1'b0, sfo_r} + {1'b0, sfs_r}) begin
              seg_r   <= seg_r + 1'b1;
              base_r  <= base_r + 32'(phent);
              wpos_r  <= {1'b0, pos_r} + 33'd1;
              wret_r  <= 1'b0;
              state_r <= ST_WCHK;
            end else begin
              state_r <= ST_FIN;
            end
          end
          ST_FIN: begin
            if (pos_r == 32'hffff_ffff) begin
              if (mode_r == MODE_CAPTURE || mode_r == MODE_STREAM) begin
                mode_r <= MODE_ENDED;
              end
            end else begin
              pos_r <= pos_r + 32'd1;
            end
            state_r <= ST_FLUSH;
          end
          ST_FLUSH: begin
            state_r <= ST_IDLE;
          end
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

FILE: design/elf_segment_image_extractor.sv
// Channel  Direction  Handshake           Beat carries
// in_      input      in_valid/in_stall   data_byte
// out_     output     out_valid/out_stall kind, byte_value, address, fill_length,
//                                         error_code, last_of_run
// cfg_     input      cfg_valid/cfg_ready start_address
//
// The front sequencer takes a byte in the header and table, or before a segment's offset, through IDLE,
// CAPT or STRA, FIN and FLUSH; a segment byte also passes STRB, STRC and STRT, and STRD when a fill run goes out first.
// At a segment boundary the table walk visits WCHK per entry and, per field, four byte reads (WISS, WGET)
// and then a decode (WDEC); a skipped entry reads type and filesz, a load entry also offset and paddr.
// Synchronous active-low reset; the table RAM needs no clearing pass.
// Results pass through a 4-beat queue, so out_stall only stops the front when full.
module elf_segment_image_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_data_byte,
  output logic        in_stall,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic [31:0] out_address,
  output logic [31:0] out_fill_length,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);
  import esie_pkg::*;

  logic    q_full;
  logic    q_push;
  result_t q_data;
  result_t out_rec;

  esie_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  esie_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_rec)
  );

  assign out_kind        = out_rec.kind;
  assign out_byte_value  = out_rec.byte_value;
  assign out_address     = out_rec.address;
  assign out_fill_length = out_rec.fill_length;
  assign out_error_code  = out_rec.error_code;
  assign out_last_of_run = out_rec.last_of_run;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import esie_pkg::*;

  typedef enum logic [1:0] {M_CAPTURE, M_STREAM, M_ENDED, M_FAILED} mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_stall;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte_value;
  logic [31:0] out_address;
  logic [31:0] out_fill_length;
  logic [1:0]  out_error_code;
  logic        out_last_of_run;

  elf_segment_image_extractor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data_byte(in_data_byte), .in_stall(in_stall),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_byte_value(out_byte_value), .out_address(out_address),
    .out_fill_length(out_fill_length), .out_error_code(out_error_code),
    .out_last_of_run(out_last_of_run)
  );

  always #10 clk = ~clk;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int failures = 0;
  int bytes_sent = 0;
  int beats_seen = 0;

  // Image predictor state.
  logic [31:0] img_start;
  logic [31:0] rd_pos;
  logic [31:0] out_addr;
  logic [7:0]  hdr [HDR_LEN];
  logic [7:0]  tab [TABLE_BYTES];
  logic [31:0] seg_idx;
  logic [31:0] seg_off;
  logic [31:0] seg_phys;
  logic [31:0] seg_size;
  mode_t       mode;

  result_t pending_beats[$];
  result_t step_beats[$];

  // The ELF file built for this run.
  logic [7:0] file_img [320];

  function automatic logic [15:0] h16(int o);
    return {hdr[o+1], hdr[o]};
  endfunction

  function automatic logic [31:0] h32(int o);
    return {h16(o + 2), h16(o)};
  endfunction

  function automatic logic [63:0] tab_size();
    return 64'(h16(42)) * 64'(h16(44));
  endfunction

  function automatic logic [31:0] entry_word(logic [31:0] seg, int field);
    logic [63:0] base;
    logic [63:0] idx;
    logic [31:0] v;
    base = 64'(seg) * 64'(h16(42)) + 64'(field);
    v = 32'd0;
    for (int b = 0; b < 4; b++) begin
      idx = base + 64'(b);
      if (idx < tab_size() && idx < TABLE_BYTES) v[8*b +: 8] = tab[idx];
    end
    return v;
  endfunction

  function automatic void emit_beat(logic [1:0] k, logic [7:0] v, logic [31:0] a,
                                    logic [31:0] l, logic [1:0] e);
    result_t r;
    r.kind = k; r.byte_value = v; r.address = a;
    r.fill_length = l; r.error_code = e; r.last_of_run = 1'b0;
    step_beats.push_back(r);
  endfunction

  // Looks for the next load segment starting at seg_idx.
  function automatic void next_segment(logic [63:0] pos);
    logic [31:0] etype;
    logic [31:0] fsz;
    logic [31:0] off;
    while (seg_idx < 32'(h16(44))) begin
      etype = entry_word(seg_idx, 0);
      fsz = entry_word(seg_idx, 16);
      if (etype != PT_LOAD || fsz == 32'd0) begin
        seg_idx++;
        continue;
      end
      off = entry_word(seg_idx, 4);
      if (64'(off) < pos) begin
        mode = M_FAILED;
        emit_beat(KIND_ERROR, 8'd0, 32'd0, 32'd0, ERR_BEHIND);
        return;
      end
      seg_off = off;
      seg_phys = entry_word(seg_idx, 12);
      seg_size = fsz;
      mode = M_STREAM;
      return;
    end
    mode = M_ENDED;
    emit_beat(KIND_END, 8'd0, 32'd0, 32'd0, ERR_NOT_ARM);
  endfunction

  function automatic void segment_byte(logic [31:0] pos, logic [7:0] b);
    logic [31:0] phys;
    if (pos < seg_off) return;
    phys = seg_phys + (pos - seg_off);
    if (phys > out_addr) begin
      emit_beat(KIND_FILL, 8'd0, out_addr, phys - out_addr, ERR_NOT_ARM);
      out_addr = phys;
    end
    if (phys >= out_addr) begin
      emit_beat(KIND_DATA, b, phys, 32'd0, ERR_NOT_ARM);
      out_addr = phys + 32'd1;
    end
    if (64'(pos) + 64'd1 == 64'(seg_off) + 64'(seg_size)) begin
      seg_idx = (seg_idx + 32'd1) & 32'h0000ffff;
      next_segment(64'(pos) + 64'd1);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    logic [31:0] pos;
    logic [31:0] tstart;
    logic [63:0] tsize;
    logic [63:0] tend;
    pos = rd_pos;
    step_beats.delete();
    if (mode == M_ENDED || mode == M_FAILED) return;
    if (mode == M_CAPTURE) begin
      if (pos < HDR_LEN) begin
        hdr[pos] = b;
        if (pos == HDR_LEN - 1 &&
            (h32(0) != ELF_MAGIC || h16(16) != ELF_EXEC || h16(18) != MACHINE_ARM)) begin
          mode = M_FAILED;
          emit_beat(KIND_ERROR, 8'd0, 32'd0, 32'd0, ERR_NOT_ARM);
        end
      end else begin
        tstart = h32(28);
        tsize = tab_size();
        tend = 64'(tstart) + tsize;
        if (pos >= tstart) begin
          if (tsize > TABLE_BYTES || tend > 64'hffffffff) begin
            mode = M_FAILED;
            emit_beat(KIND_ERROR, 8'd0, 32'd0, 32'd0, ERR_TABLE_BIG);
          end else if (64'(pos) < tend) begin
            if (pos - tstart < TABLE_BYTES) tab[pos - tstart] = b;
            if (64'(pos) + 64'd1 == tend) next_segment(64'(pos) + 64'd1);
          end else begin
            next_segment(64'(pos));
            if (mode == M_STREAM) segment_byte(pos, b);
          end
        end
      end
    end else begin
      segment_byte(pos, b);
    end
    if (pos == 32'hffffffff) begin
      if (mode == M_CAPTURE || mode == M_STREAM) begin
        mode = M_ENDED;
        emit_beat(KIND_END, 8'd0, 32'd0, 32'd0, ERR_NOT_ARM);
      end
    end else begin
      rd_pos = pos + 32'd1;
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last_of_run = 1'b1;
    foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data_byte = b;
    do @(posedge clk); while (in_stall);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_start(input logic [31:0] v);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    img_start = v;
    if (rd_pos == 32'd0) out_addr = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d addr=%h", $realtime, out_kind, out_address);
        failures++;
      end else begin
        want = pending_beats.pop_front();
        if (out_kind !== want.kind || out_byte_value !== want.byte_value ||
            out_address !== want.address || out_fill_length !== want.fill_length ||
            out_error_code !== want.error_code || out_last_of_run !== want.last_of_run) begin
          $display("%0t: mismatch expected k=%0d v=%h a=%h l=%h e=%0d last=%b",
                   $realtime, want.kind, want.byte_value, want.address, want.fill_length,
                   want.error_code, want.last_of_run);
          $display("%0t:          actual   k=%0d v=%h a=%h l=%h e=%0d last=%b",
                   $realtime, out_kind, out_byte_value, out_address, out_fill_length,
                   out_error_code, out_last_of_run);
          failures++;
        end
      end
    end
  end

  function automatic void put16(int o, logic [15:0] v);
    file_img[o] = v[7:0];
    file_img[o+1] = v[15:8];
  endfunction

  function automatic void put32(int o, logic [31:0] v);
    put16(o, v[15:0]);
    put16(o + 2, v[31:16]);
  endfunction

  // Program header entry of 20 bytes: type, offset, vaddr, paddr, filesz.
  function automatic void put_entry(int n, logic [31:0] etype, logic [31:0] off,
                                    logic [31:0] paddr, logic [31:0] fsz);
    int e;
    e = 52 + 20 * n;
    put32(e, etype);
    put32(e + 4, off);
    put32(e + 8, $urandom);
    put32(e + 12, paddr);
    put32(e + 16, fsz);
  endfunction

  task automatic test_start_register();
    // Extremes first; the last write before the first byte sets the image base.
    write_start(32'h00000000);
    write_start(32'hffffffff);
    write_start($urandom);
  endtask

  task automatic build_file(input bit behind_last);
    logic [31:0] p2;
    foreach (file_img[i]) file_img[i] = 8'($urandom);
    put32(0, ELF_MAGIC);
    put16(16, ELF_EXEC);
    put16(18, MACHINE_ARM);
    put32(28, 32'd52);
    put16(42, 16'd20);
    put16(44, 16'd5);
    p2 = img_start + $urandom_range(1, 8);
    put_entry(0, PT_LOAD, 32'd154, $urandom, 32'd0);
    put_entry(1, 32'd6, 32'd154, $urandom, 32'd10);
    // Segment two starts after a forward gap, so a fill run comes first.
    put_entry(2, PT_LOAD, 32'd156, p2, 32'd60);
    // Segment three overlaps the tail of segment two in address space.
    put_entry(3, PT_LOAD, 32'd220, p2 + 32'd40, 32'd50);
    put_entry(4, PT_LOAD, behind_last ? 32'd100 : 32'd272, $urandom, 32'd40);
  endtask

  task automatic test_header_and_table();
    send_idle_pct = 20;
    stall_pct = 74;
    for (int i = 0; i < 152; i++) send_byte(file_img[i]);
    wait_drained();
    // The image base is already latched; this write must not move it.
    write_start($urandom);
  endtask

  task automatic test_segments();
    send_idle_pct = 74;
    stall_pct = 20;
    for (int i = 152; i < 240; i++) send_byte(file_img[i]);
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 240; i < 320; i++) send_byte(file_img[i]);
  endtask

  task automatic test_ignored_tail();
    for (int i = 0; i < 12; i++) send_byte(8'($urandom));
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    img_start = 32'd0;
    rd_pos = 32'd0;
    out_addr = 32'd0;
    foreach (hdr[i]) hdr[i] = 8'd0;
    foreach (tab[i]) tab[i] = 8'd0;
    seg_idx = 32'd0;
    seg_off = 32'd0;
    seg_phys = 32'd0;
    seg_size = 32'd0;
    mode = M_CAPTURE;
    test_start_register();
    build_file($urandom_range(2) == 0);
    test_header_and_table();
    test_segments();
    test_ignored_tail();
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d file bytes at base %h; checked %0d result beats.",
             bytes_sent, img_start, beats_seen);
    $display("Covered header, table, skipped entries, fill, overlap drop and end or error.");
    if (failures == 0 && pending_beats.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
